>>> hdl/i2a_pkg.sv
package i2a_pkg;

    // field widths
    localparam int VALUE_W     = 64;
    localparam int OPCODE_W    = 3;
    localparam int MINW_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;

    // limits
    localparam int MAX_WIDTH    = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int NCELL        = 20;  // decimal digits of a 64-bit value
    localparam int PTR_DIGITS   = 16;
    localparam int PTR_PREFIX   = 2;
    localparam int CONV_STEPS   = VALUE_W;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_SDEC    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_UDEC    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HEXL    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_HEXU    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_POINTER = 3'd4;

    // characters
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    localparam logic [CHAR_W-1:0] HEX_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [CHAR_W-1:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // what every cell of the digit row does in a cycle
    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_LOAD   = 2'd1,
        CM_DABBLE = 2'd2,
        CM_SHIFT  = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       serial_in;  // next magnitude bit into the lowest cell
    } chain_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        digit_char = upper ? HEX_UPPER[d] : HEX_LOWER[d];
    endfunction

endpackage

>>> hdl/i2a_req_if.sv
interface i2a_req_if;
    logic                           valid;
    logic                           ready;
    logic [i2a_pkg::OPCODE_W-1:0]   opcode;
    logic                           wide_arg;
    logic [i2a_pkg::VALUE_W-1:0]    value_bits;
    logic [i2a_pkg::MINW_W-1:0]     min_width;
    logic                           zero_pad;

    modport source (
        output valid, opcode, wide_arg, value_bits, min_width, zero_pad,
        input  ready
    );
    modport sink (
        input  valid, opcode, wide_arg, value_bits, min_width, zero_pad,
        output ready
    );
endinterface

>>> hdl/i2a_chr_if.sv
interface i2a_chr_if;
    logic                         valid;
    logic                         ready;
    logic [i2a_pkg::CHAR_W-1:0]   out_char;
    logic                         last_char;

    modport source (
        output valid, out_char, last_char,
        input  ready
    );
    modport sink (
        input  valid, out_char, last_char,
        output ready
    );
endinterface

>>> hdl/i2a_cell.sv
module i2a_cell (
    input  logic                          clk,
    input  i2a_pkg::chain_ctrl_t          ctrl,
    input  logic [i2a_pkg::DIGIT_W-1:0]   load_digit,
    input  logic [i2a_pkg::DIGIT_W-1:0]   lower_digit,
    input  logic                          lower_carry,
    output logic [i2a_pkg::DIGIT_W-1:0]   digit,
    output logic                          carry
);

    logic [i2a_pkg::DIGIT_W-1:0] digit_reg;
    logic [i2a_pkg::DIGIT_W-1:0] digit_next;
    logic [i2a_pkg::DIGIT_W-1:0] adj;

    // add-3 correction before the shift keeps the digit decimal
    assign adj   = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry = adj[3];
    assign digit = digit_reg;

    always_comb
    begin
        case (ctrl.mode)
            i2a_pkg::CM_LOAD:   digit_next = load_digit;
            i2a_pkg::CM_DABBLE: digit_next = {adj[2:0], lower_carry};
            i2a_pkg::CM_SHIFT:  digit_next = lower_digit;
            default:            digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

>>> hdl/i2a_digit_chain.sv
module i2a_digit_chain (
    input  logic                          clk,
    input  i2a_pkg::chain_ctrl_t          ctrl,
    input  logic [i2a_pkg::DIGIT_W-1:0]   load_digits [i2a_pkg::NCELL],
    output logic [i2a_pkg::DIGIT_W-1:0]   top_digit
);

    logic [i2a_pkg::DIGIT_W-1:0] digits [i2a_pkg::NCELL];
    logic                        carries [i2a_pkg::NCELL];

    for (genvar g = 0; g < i2a_pkg::NCELL; g++)
    begin : g_cell
        if (g == 0)
        begin : g_low
            i2a_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .load_digit  (load_digits[g]),
                .lower_digit ('0),
                .lower_carry (ctrl.serial_in),
                .digit       (digits[g]),
                .carry       (carries[g])
            );
        end
        else
        begin : g_up
            i2a_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .load_digit  (load_digits[g]),
                .lower_digit (digits[g-1]),
                .lower_carry (carries[g-1]),
                .digit       (digits[g]),
                .carry       (carries[g])
            );
        end
    end

    // carry out of the top cell is never set: 64 bits fit in twenty digits
    assign top_digit = digits[i2a_pkg::NCELL-1];

endmodule

>>> hdl/integer_to_ascii_formatter_top.sv
// Integer-to-ASCII formatter: one request beat in (value, opcode, long flag, minimum
// width, pad choice), then one output beat per character, most significant first,
// with last_char on the final one. Digits live in a row of twenty 4-bit cells. A
// decimal request runs the value through the row by shift-and-add-3, one bit per
// cycle; hex and pointer requests load the nibbles straight into the cells. The row
// then shifts up past at most 19 leading zeros, one cell per cycle, sets the pad and
// digit counts, and finally shifts out one digit per emitted character. A request
// gives at most 32 characters. Requests are taken only between conversions; an
// opcode above pointer is taken and gives no output. Width saturates at MAX_WIDTH
// and never above 32.
module integer_to_ascii_formatter_top #(
    parameter int MAX_WIDTH = i2a_pkg::MAX_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    i2a_req_if.sink   req,
    i2a_chr_if.source chr
);

    // effective width cap and the bits needed to hold it
    localparam int CAP     = (MAX_WIDTH < i2a_pkg::RESULT_LIMIT) ? MAX_WIDTH
                                                                 : i2a_pkg::RESULT_LIMIT;
    localparam int WIDTH_W = $clog2(CAP + 1);
    localparam int NORM_W  = $clog2(i2a_pkg::NCELL);
    localparam int DIG_W   = $clog2(i2a_pkg::NCELL + 1);
    localparam int CONV_W  = $clog2(i2a_pkg::CONV_STEPS);
    localparam int PAD_W   = (WIDTH_W > DIG_W) ? WIDTH_W : DIG_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_NORM = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    // control state
    state_t                          state_reg, state_next;
    logic [CONV_W-1:0]               conv_cnt_reg, conv_cnt_next;
    logic [NORM_W-1:0]               norm_cnt_reg, norm_cnt_next;
    logic [1:0]                      prefix_cnt_reg, prefix_cnt_next;
    logic                            sign_reg, sign_next;
    logic [PAD_W-1:0]                pad_cnt_reg, pad_cnt_next;
    logic [DIG_W-1:0]                dig_cnt_reg, dig_cnt_next;
    logic                            out_valid_reg, out_valid_next;

    // payload
    logic [i2a_pkg::VALUE_W-1:0]     mag_reg, mag_next;
    logic [WIDTH_W-1:0]              width_reg, width_next;
    logic [i2a_pkg::CHAR_W-1:0]      pad_char_reg, pad_char_next;
    logic                            upper_reg, upper_next;
    logic [i2a_pkg::CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;

    // request decode
    logic [i2a_pkg::VALUE_W-1:0]     sext, zext, mag_in;
    logic                            neg_in, hex_in, ptr_in;
    logic [WIDTH_W-1:0]              width_sat, width_in;

    i2a_pkg::chain_ctrl_t            chain_ctrl;
    logic [i2a_pkg::DIGIT_W-1:0]     load_digits [i2a_pkg::NCELL];
    logic [i2a_pkg::DIGIT_W-1:0]     top_digit;

    logic                            accept, emit_step;
    logic [DIG_W-1:0]                len;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    // an output beat may be produced when the output register is free or draining
    assign emit_step     = (state_reg == S_EMIT) && (!out_valid_reg || chr.ready);

    assign chr.valid     = out_valid_reg;
    assign chr.out_char  = out_char_reg;
    assign chr.last_char = out_last_reg;

    // argument extension and magnitude
    always_comb
    begin
        sext   = req.wide_arg ? req.value_bits
                              : {{32{req.value_bits[31]}}, req.value_bits[31:0]};
        zext   = req.wide_arg ? req.value_bits : {32'd0, req.value_bits[31:0]};
        neg_in = 1'b0;
        case (req.opcode)
            i2a_pkg::OP_SDEC:
            begin
                neg_in = sext[i2a_pkg::VALUE_W-1];
                mag_in = neg_in ? (~sext + 64'd1) : sext;
            end
            i2a_pkg::OP_UDEC, i2a_pkg::OP_HEXL, i2a_pkg::OP_HEXU:
                mag_in = zext;
            default:
                mag_in = req.value_bits;
        endcase
        hex_in = req.opcode inside {i2a_pkg::OP_HEXL, i2a_pkg::OP_HEXU, i2a_pkg::OP_POINTER};
        ptr_in = (req.opcode == i2a_pkg::OP_POINTER);

        width_sat = (req.min_width > i2a_pkg::MINW_W'(CAP)) ? WIDTH_W'(CAP)
                                                            : WIDTH_W'(req.min_width);
        if (ptr_in)
            width_in = WIDTH_W'(i2a_pkg::PTR_DIGITS);
        else if (neg_in && (width_sat != '0))
            width_in = width_sat - 1'b1;  // the sign takes one column
        else
            width_in = width_sat;
    end

    // hex digits go straight into the low cells, decimal starts from all zeros
    for (genvar g = 0; g < i2a_pkg::NCELL; g++)
    begin : g_load
        if (g < i2a_pkg::PTR_DIGITS)
        begin : g_nib
            assign load_digits[g] = hex_in ? mag_in[g*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W]
                                           : '0;
        end
        else
        begin : g_zero
            assign load_digits[g] = '0;
        end
    end

    // significant digit count once leading zeros are shifted out
    assign len = DIG_W'(i2a_pkg::NCELL) - DIG_W'(norm_cnt_reg);

    always_comb
    begin
        state_next       = state_reg;
        conv_cnt_next    = conv_cnt_reg;
        norm_cnt_next    = norm_cnt_reg;
        prefix_cnt_next  = prefix_cnt_reg;
        sign_next        = sign_reg;
        pad_cnt_next     = pad_cnt_reg;
        dig_cnt_next     = dig_cnt_reg;
        mag_next         = mag_reg;
        width_next       = width_reg;
        pad_char_next    = pad_char_reg;
        upper_next       = upper_reg;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = chr.ready ? 1'b0 : out_valid_reg;
        chain_ctrl.mode      = i2a_pkg::CM_HOLD;
        chain_ctrl.serial_in = mag_reg[i2a_pkg::VALUE_W-1];

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.opcode <= i2a_pkg::OP_POINTER))
                begin
                    chain_ctrl.mode = i2a_pkg::CM_LOAD;
                    mag_next        = mag_in;
                    width_next      = width_in;
                    pad_char_next   = (ptr_in || req.zero_pad) ? i2a_pkg::CH_ZERO
                                                               : i2a_pkg::CH_SPACE;
                    upper_next      = (req.opcode == i2a_pkg::OP_HEXU);
                    sign_next       = neg_in;
                    prefix_cnt_next = ptr_in ? 2'(i2a_pkg::PTR_PREFIX) : 2'd0;
                    conv_cnt_next   = '0;
                    norm_cnt_next   = '0;
                    state_next      = hex_in ? S_NORM : S_CONV;
                end
            end

            S_CONV:
            begin
                // one magnitude bit into the row per cycle
                chain_ctrl.mode = i2a_pkg::CM_DABBLE;
                mag_next        = {mag_reg[i2a_pkg::VALUE_W-2:0], 1'b0};
                conv_cnt_next   = conv_cnt_reg + 1'b1;
                if (conv_cnt_reg == CONV_W'(i2a_pkg::CONV_STEPS - 1))
                    state_next = S_NORM;
            end

            S_NORM:
            begin
                // skip leading zeros but always keep one digit
                if ((top_digit == '0) && (norm_cnt_reg != NORM_W'(i2a_pkg::NCELL - 1)))
                begin
                    chain_ctrl.mode = i2a_pkg::CM_SHIFT;
                    norm_cnt_next   = norm_cnt_reg + 1'b1;
                end
                else
                begin
                    dig_cnt_next = len;
                    pad_cnt_next = (PAD_W'(width_reg) > PAD_W'(len))
                                   ? PAD_W'(width_reg) - PAD_W'(len) : '0;
                    state_next   = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (emit_step)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    if (prefix_cnt_reg != 2'd0)
                    begin
                        out_char_next   = (prefix_cnt_reg == 2'(i2a_pkg::PTR_PREFIX))
                                          ? i2a_pkg::CH_ZERO : i2a_pkg::CH_X;
                        prefix_cnt_next = prefix_cnt_reg - 1'b1;
                    end
                    else if (sign_reg)
                    begin
                        out_char_next = i2a_pkg::CH_MINUS;
                        sign_next     = 1'b0;
                    end
                    else if (pad_cnt_reg != '0)
                    begin
                        out_char_next = pad_char_reg;
                        pad_cnt_next  = pad_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        // digits leave from the top cell, the row moves up behind it
                        out_char_next   = i2a_pkg::digit_char(top_digit, upper_reg);
                        chain_ctrl.mode = i2a_pkg::CM_SHIFT;
                        dig_cnt_next    = dig_cnt_reg - 1'b1;
                        if (dig_cnt_reg == DIG_W'(1))
                        begin
                            out_last_next = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    i2a_digit_chain u_chain (
        .clk         (clk),
        .ctrl        (chain_ctrl),
        .load_digits (load_digits),
        .top_digit   (top_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            conv_cnt_reg   <= '0;
            norm_cnt_reg   <= '0;
            prefix_cnt_reg <= '0;
            sign_reg       <= 1'b0;
            pad_cnt_reg    <= '0;
            dig_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            conv_cnt_reg   <= conv_cnt_next;
            norm_cnt_reg   <= norm_cnt_next;
            prefix_cnt_reg <= prefix_cnt_next;
            sign_reg       <= sign_next;
            pad_cnt_reg    <= pad_cnt_next;
            dig_cnt_reg    <= dig_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        width_reg    <= width_next;
        pad_char_reg <= pad_char_next;
        upper_reg    <= upper_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> hdl/i2a_checker.sv
module i2a_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [i2a_pkg::OPCODE_W-1:0]  req_opcode,
    input logic                          chr_valid,
    input logic                          chr_ready,
    input logic [i2a_pkg::CHAR_W-1:0]    chr_out_char,
    input logic                          chr_last_char
);

    // a stalled output beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && !chr_ready |=> chr_valid)
        else $error("output beat dropped while stalled");

    // a stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && !chr_ready |=> $stable(chr_out_char) && $stable(chr_last_char))
        else $error("output payload changed while stalled");

    // a valid request blocks the next one while it converts
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_opcode <= i2a_pkg::OP_POINTER) |=> !req_ready)
        else $error("request taken during a conversion");

    // an undefined opcode is dropped and the block stays free
    a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_opcode > i2a_pkg::OP_POINTER) |=> req_ready)
        else $error("undefined opcode started a conversion");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_opcode    (req.opcode),
    .chr_valid     (chr.valid),
    .chr_ready     (chr.ready),
    .chr_out_char  (chr.out_char),
    .chr_last_char (chr.last_char)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    // one expected character beat on the output channel
    typedef struct {
        logic [i2a_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } char_beat_t;

    // opcodes past pointer mode are taken but give no characters
    localparam logic [i2a_pkg::OPCODE_W-1:0] OP_UNDEF_LO = i2a_pkg::OP_POINTER + 3'd1;
    localparam logic [i2a_pkg::OPCODE_W-1:0] OP_UNDEF_HI = 3'd7;

    // letters for hex digits ten and up
    localparam logic [i2a_pkg::CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [i2a_pkg::CHAR_W-1:0] CH_UPPER_A = 8'h41;

    // long enough to cover a decimal request's conversion and normalisation before its first beat
    localparam int SETTLE_CYCLES = 120;
    // cycles with no beat on either channel before the run is declared hung
    localparam int HANG_LIMIT    = 5000;

    logic clk;
    logic rst_n;

    i2a_req_if req_bus ();
    i2a_chr_if chr_bus ();

    integer_to_ascii_formatter_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .chr   (chr_bus)
    );

    // characters still owed by the block, oldest first
    char_beat_t expected_chars[$];

    int mismatch_count;
    int requests_sent;
    int chars_checked;
    int undefined_sent;
    int hang_cycles;

    // idling knobs, in percent, changed between phases
    int send_idle_pct;
    int recv_stall_pct;

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // all block inputs known from time zero
    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.opcode     = i2a_pkg::OP_SDEC;
        req_bus.wide_arg   = 1'b0;
        req_bus.value_bits = '0;
        req_bus.min_width  = '0;
        req_bus.zero_pad   = 1'b0;
        chr_bus.ready      = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        mismatch_count     = 0;
        requests_sent      = 0;
        chars_checked      = 0;
        undefined_sent     = 0;
    end

    // ------------------------------------------------------------------
    // predictor: the characters one request should produce
    // ------------------------------------------------------------------
    function automatic void format_integer(input logic [i2a_pkg::OPCODE_W-1:0] opcode,
                                           input logic                         wide,
                                           input logic [i2a_pkg::VALUE_W-1:0]  raw,
                                           input logic [i2a_pkg::MINW_W-1:0]   min_width,
                                           input logic                         zero_pad);
        logic [i2a_pkg::VALUE_W-1:0] mag;
        logic [i2a_pkg::VALUE_W-1:0] signed_val;
        logic [i2a_pkg::VALUE_W-1:0] radix;
        logic [3:0]                  d;
        logic                        upper;
        logic                        neg;
        logic                        pointer;
        logic [i2a_pkg::CHAR_W-1:0]  pad;
        logic [i2a_pkg::CHAR_W-1:0]  digits[$];
        logic [i2a_pkg::CHAR_W-1:0]  line[$];
        int                          fld;
        char_beat_t                  beat;

        if (opcode > i2a_pkg::OP_POINTER)
            return;

        fld = min_width;
        if (fld > i2a_pkg::MAX_WIDTH)
            fld = i2a_pkg::MAX_WIDTH;
        if (fld > i2a_pkg::RESULT_LIMIT)
            fld = i2a_pkg::RESULT_LIMIT;

        radix   = 64'd10;
        upper   = 1'b0;
        neg     = 1'b0;
        pointer = 1'b0;
        pad     = zero_pad ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;

        case (opcode)
            i2a_pkg::OP_SDEC:
            begin
                signed_val = wide ? raw : {{32{raw[31]}}, raw[31:0]};
                neg        = signed_val[i2a_pkg::VALUE_W-1];
                mag        = neg ? (~signed_val + 64'd1) : signed_val;
            end
            i2a_pkg::OP_UDEC:
                mag = wide ? raw : {32'd0, raw[31:0]};
            i2a_pkg::OP_HEXL, i2a_pkg::OP_HEXU:
            begin
                mag   = wide ? raw : {32'd0, raw[31:0]};
                radix = 64'd16;
                upper = (opcode == i2a_pkg::OP_HEXU);
            end
            default:
            begin
                // pointer: all 64 bits, fixed 16 zero-padded digits
                mag     = raw;
                radix   = 64'd16;
                pointer = 1'b1;
                fld     = i2a_pkg::PTR_DIGITS;
                pad     = i2a_pkg::CH_ZERO;
            end
        endcase

        // digits, most significant at the front
        do
        begin
            d = 4'(mag % radix);
            if (d < 4'd10)
                digits.push_front(i2a_pkg::CH_ZERO + i2a_pkg::CHAR_W'(d));
            else
                digits.push_front((upper ? CH_UPPER_A : CH_LOWER_A)
                                  + i2a_pkg::CHAR_W'(d) - 8'd10);
            mag = mag / radix;
        end
        while (mag != 0);

        if (pointer)
        begin
            line.push_back(i2a_pkg::CH_ZERO);
            line.push_back(i2a_pkg::CH_X);
        end
        if (neg)
        begin
            line.push_back(i2a_pkg::CH_MINUS);
            if (fld > 0)
                fld--;
        end
        // pad sits between the sign and the digits
        for (int i = digits.size(); i < fld; i++)
            line.push_back(pad);
        foreach (digits[i])
            line.push_back(digits[i]);

        foreach (line[i])
        begin
            if (i < i2a_pkg::RESULT_LIMIT)
            begin
                beat.ch   = line[i];
                beat.last = (i == line.size() - 1) || (i == i2a_pkg::RESULT_LIMIT - 1);
                expected_chars.push_back(beat);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_request(input logic [i2a_pkg::OPCODE_W-1:0] opcode,
                                input logic                         wide,
                                input logic [i2a_pkg::VALUE_W-1:0]  value,
                                input logic [i2a_pkg::MINW_W-1:0]   min_width,
                                input logic                         zero_pad);
        // random gaps before the beat
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge clk);
        req_bus.valid      <= 1'b1;
        req_bus.opcode     <= opcode;
        req_bus.wide_arg   <= wide;
        req_bus.value_bits <= value;
        req_bus.min_width  <= min_width;
        req_bus.zero_pad   <= zero_pad;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        // beat taken at this edge
        format_integer(opcode, wide, value, min_width, zero_pad);
        requests_sent++;
        if (opcode > i2a_pkg::OP_POINTER)
            undefined_sent++;
    endtask

    // hold the request side quiet until every owed character is back
    task automatic drain_chars();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        // an undefined opcode may still be in flight with nothing owed
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls and the character check
    // ------------------------------------------------------------------
    always @(negedge clk)
        chr_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && chr_bus.valid && chr_bus.ready)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected char beat, expected none actual %h last %b",
                         $time, chr_bus.out_char, chr_bus.last_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (chr_bus.out_char !== want.ch)
                begin
                    mismatch_count++;
                    $display("%0t: out_char mismatch, expected %h actual %h",
                             $time, want.ch, chr_bus.out_char);
                end
                if (chr_bus.last_char !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: last_char mismatch, expected %b actual %b",
                             $time, want.last, chr_bus.last_char);
                end
            end
        end
    end

    // hang detector: counts cycles with no beat on either side
    initial
    begin
        hang_cycles = 0;
        while (hang_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (chr_bus.valid && chr_bus.ready))
                hang_cycles = 0;
            else
                hang_cycles++;
        end
        $display("%0t: no beat for %0d cycles, %0d chars still owed",
                 $time, HANG_LIMIT, expected_chars.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // random request content
    // ------------------------------------------------------------------
    function automatic logic [i2a_pkg::VALUE_W-1:0] pick_value();
        logic [i2a_pkg::VALUE_W-1:0] v;
        case ($urandom_range(6))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(999));
            2: v = -64'($urandom_range(1, 999));
            3: v = 64'd1 << $urandom_range(63);
            4: v = {$urandom, ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff)};
            5: v = ($urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff)
                   ^ 64'($urandom_range(3));
            default: v = ~64'($urandom_range(15));
        endcase
        return v;
    endfunction

    function automatic logic [i2a_pkg::OPCODE_W-1:0] pick_opcode();
        if ($urandom_range(99) < 6)
            return i2a_pkg::OPCODE_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        return i2a_pkg::OPCODE_W'($urandom_range(i2a_pkg::OP_SDEC, i2a_pkg::OP_POINTER));
    endfunction

    function automatic logic [i2a_pkg::MINW_W-1:0] pick_width();
        // mostly short fields, now and then past saturation
        if ($urandom_range(99) < 15)
            return i2a_pkg::MINW_W'($urandom_range(25, 63));
        return i2a_pkg::MINW_W'($urandom_range(0, 24));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // signed and unsigned decimal extremes, sign handling, pad placement
    task automatic test_decimal_extremes();
        send_request(i2a_pkg::OP_SDEC, 1'b0, 64'd0, 6'd0, 1'b0);
        send_request(i2a_pkg::OP_SDEC, 1'b0, 64'hffff_ffff_8000_0000, 6'd0, 1'b0);
        send_request(i2a_pkg::OP_SDEC, 1'b1, 64'h8000_0000_0000_0000, 6'd0, 1'b0);
        send_request(i2a_pkg::OP_SDEC, 1'b1, 64'hffff_ffff_ffff_ffff, 6'd5, 1'b0);
        // upper half ignored when narrow, top bit of low word clear
        send_request(i2a_pkg::OP_SDEC, 1'b0, 64'hffff_ffff_7fff_ffff, 6'd12, 1'b1);
        // negative with full zero-padded field, then space-padded saturated field
        send_request(i2a_pkg::OP_SDEC, 1'b0, 64'h0000_0000_ffff_fff9, 6'd32, 1'b1);
        send_request(i2a_pkg::OP_SDEC, 1'b1, 64'hffff_ffff_ffff_ff85, 6'd63, 1'b0);
        send_request(i2a_pkg::OP_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff, 6'd1, 1'b1);
        send_request(i2a_pkg::OP_UDEC, 1'b1, 64'hffff_ffff_ffff_ffff, 6'd63, 1'b1);
        send_request(i2a_pkg::OP_UDEC, 1'b0, 64'hffff_ffff_ffff_ffff, 6'd0, 1'b0);
        // digits wider than the field are never cut
        send_request(i2a_pkg::OP_UDEC, 1'b1, 64'd12345, 6'd2, 1'b0);
    endtask

    // both hex cases and pointer mode, which ignores width, pad and long flag
    task automatic test_hex_and_pointer();
        send_request(i2a_pkg::OP_HEXL, 1'b1, 64'hdead_beef_cafe_f00d, 6'd0, 1'b0);
        send_request(i2a_pkg::OP_HEXU, 1'b1, 64'hdead_beef_cafe_f00d, 6'd20, 1'b0);
        send_request(i2a_pkg::OP_HEXL, 1'b0, 64'h1234_5678_9abc_def0, 6'd1, 1'b1);
        send_request(i2a_pkg::OP_HEXU, 1'b0, 64'd0, 6'd32, 1'b1);
        send_request(i2a_pkg::OP_HEXU, 1'b1, 64'hffff_ffff_ffff_ffff, 6'd33, 1'b0);
        send_request(i2a_pkg::OP_POINTER, 1'b0, 64'd0, 6'd40, 1'b0);
        send_request(i2a_pkg::OP_POINTER, 1'b1, 64'hffff_ffff_ffff_ffff, 6'd0, 1'b1);
        send_request(i2a_pkg::OP_POINTER, 1'b0, 64'h0123_4567_89ab_cdef, 6'd63, 1'b0);
    endtask

    // undefined opcodes must be taken silently, with legal ones around them
    task automatic test_undefined_opcodes();
        send_request(OP_UNDEF_LO, 1'b1, 64'h5555_5555_5555_5555, 6'd10, 1'b1);
        send_request(i2a_pkg::OP_UDEC, 1'b0, 64'd7, 6'd3, 1'b1);
        send_request(OP_UNDEF_LO + 3'd1, 1'b0, 64'haaaa_aaaa_aaaa_aaaa, 6'd21, 1'b0);
        send_request(OP_UNDEF_HI, 1'b1, 64'd0, 6'd0, 1'b0);
        send_request(i2a_pkg::OP_HEXL, 1'b0, 64'd255, 6'd4, 1'b0);
    endtask

    // random requests under one idling mix
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_request(pick_opcode(), 1'($urandom_range(1)), pick_value(),
                         pick_width(), 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_decimal_extremes();
        test_hex_and_pointer();
        test_undefined_opcodes();
        // sender waits for the block to go fully quiet
        drain_chars();

        test_random_phase(0, 0, 32);
        test_random_phase(88, 0, 32);
        drain_chars();
        test_random_phase(0, 88, 32);
        test_random_phase(6, 6, 32);

        drain_chars();

        $display("covered %0d requests (%0d undefined opcodes), %0d characters checked",
                 requests_sent, undefined_sent, chars_checked);
        $display("idling mixes: none, sender 88%%, receiver 88%%, both 6%%; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
